// ===== rtl/pdu_pkg.sv =====
// -----------------------------------------------------------------------------
// pdu_pkg
// Shared widths, limits and types of the packed date unpacker.
// -----------------------------------------------------------------------------
package pdu_pkg;

    localparam int WORD_W    = 32;
    localparam int DATE_W    = 15;
    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 6;
    localparam int CARRY_W   = 14;
    localparam int CLEN_W    = 4;
    localparam int COUNT_W   = 13;
    localparam int SLOTS     = 3;
    localparam int BUF_W     = CARRY_W + WORD_W;
    localparam int MAX_DATES = 4096;
    localparam int TDATA_W   = 16;

    typedef struct packed {
        logic [YEAR_W-1:0]  year_offset;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               set_end;
    } t_date;

    typedef struct packed {
        logic [CARRY_W-1:0] bits;
        logic [CLEN_W-1:0]  len;
        logic               bad;
        logic [COUNT_W-1:0] seen;
    } t_carry;

    typedef struct packed {
        t_date [SLOTS-1:0] dates;
        logic  [SLOTS-1:0] keep;
        logic              ended;
        t_carry            carry;
    } t_dec;

endpackage

// ===== rtl/pdu_decode.sv =====
// -----------------------------------------------------------------------------
// pdu_decode
// Splice one word onto the carried bits, cut out up to three dates, apply
// the parity and set-end rules and form the next carry state.
// -----------------------------------------------------------------------------
module pdu_decode (
    input  logic [pdu_pkg::WORD_W-1:0]  i_word,
    input  logic                        i_parity,
    input  logic [pdu_pkg::COUNT_W-1:0] i_total,
    input  pdu_pkg::t_carry             i_carry,
    output pdu_pkg::t_dec               o_dec
);

    logic [pdu_pkg::CLEN_W-1:0]  w_clen;
    logic [pdu_pkg::CARRY_W:0]   w_one_sh;
    logic [pdu_pkg::CARRY_W-1:0] w_mask;
    logic [pdu_pkg::BUF_W-1:0]   w_buf;
    logic [pdu_pkg::COUNT_W-1:0] w_tot;
    logic                        w_corrupt;
    logic                        w_three;
    logic [pdu_pkg::SLOTS-1:0]   w_bad;
    logic [pdu_pkg::SLOTS-1:0]   w_last;
    logic [pdu_pkg::SLOTS-1:0]   w_proc;
    logic [pdu_pkg::COUNT_W-1:0] w_seen [pdu_pkg::SLOTS];
    logic [pdu_pkg::DATE_W-1:0]  w_raw  [pdu_pkg::SLOTS];

    always_comb begin
        w_clen = (i_carry.len > pdu_pkg::CLEN_W'(pdu_pkg::CARRY_W))
               ? pdu_pkg::CLEN_W'(pdu_pkg::CARRY_W) : i_carry.len;
        w_one_sh = (pdu_pkg::CARRY_W+1)'(1) << w_clen;
        w_mask   = pdu_pkg::CARRY_W'(w_one_sh - (pdu_pkg::CARRY_W+1)'(1));
        w_buf    = pdu_pkg::BUF_W'(i_carry.bits & w_mask)
                 | (pdu_pkg::BUF_W'(i_word) << w_clen);

        if (i_total == '0) begin
            w_tot = pdu_pkg::COUNT_W'(1);
        end else if (i_total > pdu_pkg::COUNT_W'(pdu_pkg::MAX_DATES)) begin
            w_tot = pdu_pkg::COUNT_W'(pdu_pkg::MAX_DATES);
        end else begin
            w_tot = i_total;
        end

        w_corrupt = (^i_word) != i_parity;
        w_three   = w_clen >= pdu_pkg::CLEN_W'(pdu_pkg::CARRY_W - 1);

        for (int k = 0; k < pdu_pkg::SLOTS; k++) begin
            w_raw[k]  = w_buf[k*pdu_pkg::DATE_W +: pdu_pkg::DATE_W];
            w_seen[k] = i_carry.seen + pdu_pkg::COUNT_W'(k + 1);
            w_last[k] = w_seen[k] >= w_tot;
            w_bad[k]  = w_corrupt;
        end
        w_bad[0] = w_corrupt || ((w_clen != '0) && i_carry.bad);

        w_proc[0] = 1'b1;
        w_proc[1] = !w_last[0];
        w_proc[2] = w_three && !w_last[0] && !w_last[1];

        for (int k = 0; k < pdu_pkg::SLOTS; k++) begin
            o_dec.dates[k].day         = w_raw[k][pdu_pkg::DAY_W-1:0];
            o_dec.dates[k].month       = w_raw[k][pdu_pkg::DAY_W +: pdu_pkg::MONTH_W];
            o_dec.dates[k].year_offset =
                w_raw[k][pdu_pkg::DAY_W + pdu_pkg::MONTH_W +: pdu_pkg::YEAR_W];
            o_dec.dates[k].set_end     = w_last[k] && w_proc[k];
            o_dec.keep[k]              = w_proc[k] && !w_bad[k];
        end

        o_dec.ended = |(w_last & w_proc);

        if (o_dec.ended) begin
            o_dec.carry = '0;
        end else if (w_three) begin
            o_dec.carry.len  = w_clen - pdu_pkg::CLEN_W'(pdu_pkg::CARRY_W - 1);
            o_dec.carry.bits = pdu_pkg::CARRY_W'(w_buf[pdu_pkg::BUF_W-1]);
            o_dec.carry.seen = w_seen[2];
            o_dec.carry.bad  = w_corrupt && (o_dec.carry.len != '0);
        end else begin
            o_dec.carry.len  = w_clen + pdu_pkg::CLEN_W'(2);
            o_dec.carry.bits = w_buf[2*pdu_pkg::DATE_W +: pdu_pkg::CARRY_W];
            o_dec.carry.seen = w_seen[1];
            o_dec.carry.bad  = w_corrupt && (o_dec.carry.len != '0);
        end
    end

endmodule

// ===== rtl/pdu_rbuf.sv =====
// -----------------------------------------------------------------------------
// pdu_rbuf
// Hold the kept dates of one word and hand them to the output register one
// per cycle while that register is free, marking the last of the word.
// -----------------------------------------------------------------------------
module pdu_rbuf (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load_valid,
    input  pdu_pkg::t_date [pdu_pkg::SLOTS-1:0] i_dates,
    input  logic [pdu_pkg::SLOTS-1:0] i_keep,
    output logic                      o_free,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [pdu_pkg::TDATA_W-1:0] o_m_tdata,  // day, month, year_offset, pad
    output logic                      o_m_tlast,
    output logic                      o_m_tuser     // set_end
);

    logic [pdu_pkg::SLOTS-1:0]            r_keep, n_keep;
    pdu_pkg::t_date [pdu_pkg::SLOTS-1:0]  r_dates;
    logic                                 r_o_valid;
    pdu_pkg::t_date                       r_o_date;
    logic                                 r_o_last;

    logic [pdu_pkg::SLOTS-1:0] w_sel;
    logic [pdu_pkg::SLOTS-1:0] w_rem;
    logic                      w_out_free;
    logic                      w_move;
    logic                      w_load;
    pdu_pkg::t_date            w_pick;

    always_comb begin
        w_sel  = r_keep & (~r_keep + pdu_pkg::SLOTS'(1));
        w_rem  = r_keep & ~w_sel;
        w_pick = '0;
        for (int k = 0; k < pdu_pkg::SLOTS; k++) begin
            if (w_sel[k]) begin
                w_pick = r_dates[k];
            end
        end
        w_out_free = !r_o_valid || i_m_tready;
        w_move     = w_out_free && (r_keep != '0);
        o_free     = (r_keep == '0) || (w_move && (w_rem == '0));
        w_load     = i_load_valid && o_free;
        if (w_load) begin
            n_keep = i_keep;
        end else if (w_move) begin
            n_keep = w_rem;
        end else begin
            n_keep = r_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_keep <= n_keep;
            if (w_move) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_dates <= i_dates;
        end
        if (w_move) begin
            r_o_date <= w_pick;
            r_o_last <= (w_rem == '0);
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {1'b0, r_o_date.year_offset, r_o_date.month, r_o_date.day};
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = r_o_date.set_end;

endmodule

// ===== rtl/packed_date_unpacker_parity.sv =====
// -----------------------------------------------------------------------------
// packed_date_unpacker_parity
// Unpack a parity-checked LSB-first stream of 15-bit packed dates.
// -----------------------------------------------------------------------------
// Each request is one 32-bit word with its parity bit in tuser; it yields the
// dates it completes, up to three per word and fewer when a set ends inside it,
// minus those touching a corrupt word. A word holds the block until each of its
// kept dates has gone out, since the single output register emits one date per
// cycle while tready is high; words with up to one kept date stream at one per
// cycle while the output does not stall. A taken word passes through the input
// register, the date buffer and the output register. tlast marks the last date
// of a word and tuser the date that closes a set of date_total dates.
module packed_date_unpacker_parity (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [pdu_pkg::COUNT_W-1:0]   i_cfg_wr_data,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [pdu_pkg::WORD_W-1:0]    i_s_tdata,   // data_word
    input  logic                          i_s_tuser,   // parity_bit
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [pdu_pkg::TDATA_W-1:0]   o_m_tdata,   // day, month, year_offset, pad
    output logic                          o_m_tlast,   // run_end
    output logic                          o_m_tuser    // set_end
);

    logic [pdu_pkg::COUNT_W-1:0] r_date_total;
    logic                        r_a_valid;
    logic [pdu_pkg::WORD_W-1:0]  r_a_word;
    logic                        r_a_parity;
    pdu_pkg::t_carry             r_carry;

    pdu_pkg::t_dec w_dec;
    logic          w_b_free;
    logic          w_adv;

    pdu_decode u_decode (
        .i_word   (r_a_word),
        .i_parity (r_a_parity),
        .i_total  (r_date_total),
        .i_carry  (r_carry),
        .o_dec    (w_dec)
    );

    pdu_rbuf u_rbuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_a_valid),
        .i_dates      (w_dec.dates),
        .i_keep       (w_dec.keep),
        .o_free       (w_b_free),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tlast    (o_m_tlast),
        .o_m_tuser    (o_m_tuser)
    );

    assign w_adv      = r_a_valid && w_b_free;
    assign o_s_tready = !r_a_valid || w_b_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_date_total <= pdu_pkg::COUNT_W'(1);
            r_a_valid    <= 1'b0;
            r_carry      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_date_total <= i_cfg_wr_data;
            end
            if (i_s_tvalid && o_s_tready) begin
                r_a_valid <= 1'b1;
            end else if (w_b_free) begin
                r_a_valid <= 1'b0;
            end
            if (w_adv) begin
                r_carry <= w_dec.carry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_a_word   <= i_s_tdata;
            r_a_parity <= i_s_tuser;
        end
    end

    a_carry_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_carry.len <= pdu_pkg::CLEN_W'(pdu_pkg::CARRY_W))
        else $error("carry length out of range");

    a_empty_carry_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_carry.len == '0) |-> (r_carry.bits == '0 && !r_carry.bad))
        else $error("empty carry holds stale bits");

    a_set_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_dec.ended) |=> (r_carry.len == '0 && r_carry.seen == '0))
        else $error("set end did not clear state");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_a_valid && !w_b_free))
        else $error("input stalled with free stage");

endmodule
